/* hdl/hufr_pkg.sv */
// Shared types, codes and constants for the half-duplex UART framer.
package hufr_pkg;

   // Frame geometry
   localparam int unsigned DATA_BITS  = 8;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned BIT_IDX_W  = 4;

   // Register widths
   localparam int unsigned PERIOD_W   = 16;
   localparam int unsigned TIMEOUT_W  = 24;
   localparam int unsigned PKT_LEN_W  = 5;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 24;

   // Stream payload widths
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned RSP_USER_W = 2;

   // Register reset values
   localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = PERIOD_W'(104);
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100000);
   localparam logic [PKT_LEN_W-1:0] PKT_LEN_RESET = PKT_LEN_W'(8);

   // Command codes
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_SEND = 2'd1;
   localparam logic [1:0] CMD_RECV = 2'd2;

   // Receive status codes
   localparam logic [1:0] STS_OK           = 2'd0;
   localparam logic [1:0] STS_START_TMOUT  = 2'd1;
   localparam logic [1:0] STS_STOP_TMOUT   = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PKT_BYTES  = 2'd2;

   typedef struct packed {
      logic [PERIOD_W-1:0]  bit_period;
      logic [TIMEOUT_W-1:0] timeout;
      logic [PKT_LEN_W-1:0] pkt_bytes;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [BYTE_W-1:0] tx_byte;
      logic              tx_end_of_packet;
      logic              rx_level;
   } item_type;

   typedef struct packed {
      logic              tx_level;
      logic              busy_res;
      logic [BYTE_W-1:0] rx_byte;
      logic              rx_byte_valid;
      logic              rx_last;
      logic [1:0]        rx_status;
      logic              rx_status_valid;
   } result_type;

endpackage

/* hdl/half_duplex_uart_framer_top.sv */
// Top level of the half-duplex UART framer: stream ports, pipeline registers.
//
//   Channel  Dir  Handshake                Payload
//   req_     in   req_tvalid/req_tready    tuser command, tdata tx_byte/rx_level, tlast eop
//   rsp_     out  rsp_tvalid/rsp_tready    tdata line/busy/byte/status, tuser flags, tlast
//   csr_     in   csr_valid/csr_ready      csr_index, csr_data
//
// Each transfer is one tick; one transfer is taken per cycle while a stalled result does not hold the input.
// The tick is worked out between the input register and the result register.
// Reset puts the framer idle with the line high and the registers at defaults.
// A stalled result holds both stages; the input register frees when the result moves.
module half_duplex_uart_framer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] tx_byte, [8] rx_level, [15:9] zero
   input  logic [hufr_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [1:0]                      req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] tx_level, [1] busy_res, [9:2] rx_byte, [11:10] rx_status, [15:12] zero
   output logic [hufr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] rx_byte_valid, [1] rx_status_valid
   output logic [hufr_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hufr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hufr_pkg::CSR_DATA_W-1:0] csr_data
);
   import hufr_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   result_type result;
   result_type out_ff;
   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       req_xfer;

   // Move the held item into the result stage when it is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      item_in.command          = req_tuser;
      item_in.tx_byte          = req_tdata[BYTE_W-1:0];
      item_in.tx_end_of_packet = req_tlast;
      item_in.rx_level         = req_tdata[BYTE_W];
      in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   hufr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   hufr_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cfg    (cfg),
      .item   (item_ff),
      .result (result)
   );

   // Input and result stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_xfer)
         item_ff <= item_in;
      if (advance)
         out_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-12)'(0), out_ff.rx_status, out_ff.rx_byte,
                        out_ff.busy_res, out_ff.tx_level};
   assign rsp_tuser  = {out_ff.rx_status_valid, out_ff.rx_byte_valid};
   assign rsp_tlast  = out_ff.rx_last;

endmodule

/* hdl/hufr_csr.sv */
// Configuration registers of the UART framer.
module hufr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [hufr_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [hufr_pkg::CSR_DATA_W-1:0] wr_data,
   output hufr_pkg::cfg_type               cfg
);
   import hufr_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Decode a write; unknown indexes leave everything unchanged
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_BIT_PERIOD: cfg_in.bit_period = wr_data[PERIOD_W-1:0];
            CSR_TIMEOUT:    cfg_in.timeout    = wr_data[TIMEOUT_W-1:0];
            CSR_PKT_BYTES:  cfg_in.pkt_bytes  = wr_data[PKT_LEN_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period <= PERIOD_RESET;
         cfg_ff.timeout    <= TIMEOUT_RESET;
         cfg_ff.pkt_bytes  <= PKT_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/hufr_engine.sv */
// Framer state machine: one tick of transmit or receive work per transfer.
module hufr_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  hufr_pkg::cfg_type    cfg,
   input  hufr_pkg::item_type   item,
   output hufr_pkg::result_type result
);
   import hufr_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TX,
      PH_WAIT_START,
      PH_START_DELAY,
      PH_DATA,
      PH_WAIT_STOP,
      PH_STOP_DELAY
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [PERIOD_W-1:0]   bit_timer_ff, bit_timer_in;
   logic [TIMEOUT_W-1:0]  wait_timer_ff, wait_timer_in;
   logic [BIT_IDX_W-1:0]  bit_index_ff, bit_index_in;
   logic [BYTE_W-1:0]     shift_ff, shift_in;
   logic [PKT_LEN_W-1:0]  byte_count_ff, byte_count_in;
   logic                  pkt_end_ff, pkt_end_in;

   logic [PERIOD_W-1:0]   period;
   logic [PKT_LEN_W-1:0]  pkt_len;
   logic                  is_wait;
   logic                  found;
   logic [PERIOD_W-1:0]   timer_base;
   logic [PERIOD_W:0]     timer_sum;
   logic                  period_end;
   logic [BIT_IDX_W-1:0]  bit_index_inc;
   logic [BIT_IDX_W-1:0]  tx_last_index;
   logic [2:0]            tx_sel;
   logic [PKT_LEN_W-1:0]  next_count;
   logic                  do_stop;

   // Zero-valued bit-period and packet-length registers act as one
   assign period  = (cfg.bit_period == '0) ? PERIOD_W'(1) : cfg.bit_period;
   assign pkt_len = (cfg.pkt_bytes == '0) ? PKT_LEN_W'(1) : cfg.pkt_bytes;

   always_comb begin
      phase_in      = phase_ff;
      bit_timer_in  = bit_timer_ff;
      wait_timer_in = wait_timer_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      byte_count_in = byte_count_ff;
      pkt_end_in    = pkt_end_ff;
      result        = '0;
      do_stop       = 1'b0;
      next_count    = '0;
      tx_sel        = '0;
      tx_last_index = '0;

      // Start a command only from idle
      if (phase_ff == PH_IDLE) begin
         if (item.command == CMD_SEND) begin
            phase_in     = PH_TX;
            shift_in     = item.tx_byte;
            pkt_end_in   = item.tx_end_of_packet;
            bit_index_in = '0;
            bit_timer_in = '0;
         end else if (item.command == CMD_RECV) begin
            phase_in      = PH_WAIT_START;
            byte_count_in = '0;
            wait_timer_in = '0;
            bit_timer_in  = '0;
         end
      end
      result.busy_res = (phase_in != PH_IDLE);
      result.tx_level = 1'b1;

      // One shared bit-period counter step; a found level restarts the period
      is_wait    = (phase_in == PH_WAIT_START) || (phase_in == PH_WAIT_STOP);
      found      = (phase_in == PH_WAIT_START) ? !item.rx_level : item.rx_level;
      timer_base = (is_wait && found) ? '0 : bit_timer_in;
      timer_sum  = {1'b0, timer_base} + (PERIOD_W+1)'(1);
      period_end = (timer_sum >= {1'b0, period});
      bit_index_inc = bit_index_in + BIT_IDX_W'(1);

      unique case (phase_in)
         PH_IDLE: begin
            result.tx_level = 1'b1;
         end
         PH_TX: begin
            // Drive start bit, data bits LSB first, then stop level
            tx_sel = 3'(bit_index_in - BIT_IDX_W'(1));
            if (bit_index_in == '0)
               result.tx_level = 1'b0;
            else if (bit_index_in <= BIT_IDX_W'(DATA_BITS) &&
                     bit_index_in <= BIT_IDX_W'(BYTE_W))
               result.tx_level = shift_in[tx_sel];
            else if (bit_index_in <= BIT_IDX_W'(DATA_BITS))
               result.tx_level = 1'b0;
            tx_last_index = pkt_end_in ? BIT_IDX_W'(DATA_BITS + 2)
                                       : BIT_IDX_W'(DATA_BITS + 1);
            if (period_end) begin
               bit_timer_in = '0;
               bit_index_in = bit_index_inc;
               if (bit_index_inc > tx_last_index) begin
                  bit_index_in = '0;
                  phase_in     = PH_IDLE;
               end
            end else begin
               bit_timer_in = timer_sum[PERIOD_W-1:0];
            end
         end
         PH_WAIT_START, PH_WAIT_STOP: begin
            if (found) begin
               wait_timer_in = '0;
               if (phase_in == PH_WAIT_START) begin
                  shift_in     = '0;
                  bit_index_in = '0;
                  if (period_end) begin
                     bit_timer_in = '0;
                     phase_in     = PH_DATA;
                  end else begin
                     bit_timer_in = timer_sum[PERIOD_W-1:0];
                     phase_in     = PH_START_DELAY;
                  end
               end else begin
                  phase_in = PH_STOP_DELAY;
                  do_stop  = 1'b1;
               end
            end else if (wait_timer_in >= cfg.timeout) begin
               // Abort the packet on timeout
               result.rx_status = (phase_in == PH_WAIT_START) ? STS_START_TMOUT
                                                              : STS_STOP_TMOUT;
               result.rx_status_valid = 1'b1;
               wait_timer_in = '0;
               phase_in      = PH_IDLE;
            end else begin
               wait_timer_in = wait_timer_in + TIMEOUT_W'(1);
            end
         end
         PH_START_DELAY: begin
            if (period_end) begin
               bit_timer_in = '0;
               phase_in     = PH_DATA;
            end else begin
               bit_timer_in = timer_sum[PERIOD_W-1:0];
            end
         end
         PH_DATA: begin
            // Sample on the first tick of each data bit period
            if (bit_timer_in == '0 && bit_index_in < BIT_IDX_W'(BYTE_W))
               shift_in[bit_index_in[2:0]] = shift_in[bit_index_in[2:0]] | item.rx_level;
            if (period_end) begin
               bit_timer_in = '0;
               bit_index_in = bit_index_inc;
               if (bit_index_inc >= BIT_IDX_W'(DATA_BITS)) begin
                  bit_index_in         = '0;
                  result.rx_byte       = shift_in;
                  result.rx_byte_valid = 1'b1;
                  result.rx_last       = ({1'b0, byte_count_in} + (PKT_LEN_W+1)'(1))
                                         >= {1'b0, pkt_len};
                  wait_timer_in        = '0;
                  phase_in             = PH_WAIT_STOP;
               end
            end else begin
               bit_timer_in = timer_sum[PERIOD_W-1:0];
            end
         end
         PH_STOP_DELAY: begin
            do_stop = 1'b1;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // Finish the stop bit period, then next byte or end of packet
      if (do_stop) begin
         if (period_end) begin
            bit_timer_in = '0;
            next_count   = byte_count_in + PKT_LEN_W'(1);
            if (next_count >= pkt_len) begin
               byte_count_in          = '0;
               result.rx_status       = STS_OK;
               result.rx_status_valid = 1'b1;
               phase_in               = PH_IDLE;
            end else begin
               byte_count_in = next_count;
               wait_timer_in = '0;
               phase_in      = PH_WAIT_START;
            end
         end else begin
            bit_timer_in = timer_sum[PERIOD_W-1:0];
         end
      end
   end

   // Hold state; advance only when the item is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_timer_ff  <= '0;
         wait_timer_ff <= '0;
         bit_index_ff  <= '0;
         shift_ff      <= '0;
         byte_count_ff <= '0;
         pkt_end_ff    <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bit_timer_ff  <= bit_timer_in;
         wait_timer_ff <= wait_timer_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
         byte_count_ff <= byte_count_in;
         pkt_end_ff    <= pkt_end_in;
      end
   end

endmodule
